// ===== src/calculator_key_engine_macros.svh =====
`ifndef CALCULATOR_KEY_ENGINE_MACROS_SVH
`define CALCULATOR_KEY_ENGINE_MACROS_SVH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CKE_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("calculator_key_engine check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CKE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("calculator_key_engine check failed");
`endif

// ===== src/cke_pkg.sv =====
`default_nettype none
package cke_pkg;

  localparam int DIV_W       = 64;
  localparam int OUT_W       = 64;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 72;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef enum logic [2:0] {
    MODE_DIGIT = 3'd0,
    MODE_OP    = 3'd1,
    MODE_EQ    = 3'd2,
    MODE_DOT   = 3'd3,
    MODE_CLR   = 3'd4,
    MODE_CE    = 3'd5,
    MODE_PCT   = 3'd6
  } cke_mode_t;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_RESULT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_OUT
  } cke_state_t;

  typedef enum logic [1:0] {
    US_IDLE,
    US_MUL,
    US_DIV,
    US_ADD
  } cke_ustate_t;

  function automatic logic [63:0] pow10(input logic [3:0] k);
    logic [63:0] r;
    case (k)
      4'd0:    r = 64'd1;
      4'd1:    r = 64'd10;
      4'd2:    r = 64'd100;
      4'd3:    r = 64'd1000;
      4'd4:    r = 64'd10000;
      4'd5:    r = 64'd100000;
      4'd6:    r = 64'd1000000;
      4'd7:    r = 64'd10000000;
      4'd8:    r = 64'd100000000;
      4'd9:    r = 64'd1000000000;
      4'd10:   r = 64'd10000000000;
      4'd11:   r = 64'd100000000000;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/calculator_key_engine.sv =====
`default_nettype none
// Keypad logic of a four-function calculator on decimal fixed point.
// Input channel in_*: one key item per handshake. in_tuser carries the key
// kind, in_tdata the digit and operator code. Output channel out_*: exactly
// one item per key with the shown value and the status flags.
// Values are signed, scaled by 10^FRAC_DIGITS, saturated to VALUE_WIDTH bits.
// Keys handled by plain logic (operator, decimal point, clear, clear entry,
// add/subtract equals) give out_tvalid in the cycle after acceptance.
// Digits within precision, multiply and nonzero divide equals, and percent
// run through one iterative multiply/divide unit: a shift-add multiply,
// then a restoring divide, then one add step.
// One key is in flight at a time: in_tready is low from acceptance until the
// result item is taken. A stalled out_tready holds the result and the block.
// Synchronous reset (rst_n low) clears both operands, the phase, the flags
// and the shown value; the block is ready the cycle after reset is released.
module calculator_key_engine #(
  parameter int FRAC_DIGITS = 6,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [3:0] digit, [6:4] op_code, [7] zero
  input  wire logic [cke_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] mode
  input  wire logic [cke_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [63:0] display_value, [65:64] phase, [66] error_flag, [67] minus_pending,
  // [68] decimal_active, [69] overflow_flag, [71:70] zero
  output logic [cke_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  localparam int VW = VALUE_WIDTH;
  localparam int P  = 2 * VW;
  localparam int DW = cke_pkg::DIV_W;

  cke_pkg::cke_state_t state_r, state_nxt;
  logic [VW-1:0] first_r, first_nxt;
  logic [VW-1:0] second_r, second_nxt;
  logic [VW-1:0] shown_r, shown_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [2:0]    pop_r, pop_nxt;
  logic          frac_r, frac_nxt;
  logic [3:0]    place_r, place_nxt;
  logic          sign_r, sign_nxt;
  logic          err_r, err_nxt;
  logic          ovf_r, ovf_nxt;
  logic          to_second_r, to_second_nxt;
  logic          jneg_r, jneg_nxt;
  logic          dig_r, dig_nxt;
  logic          dnz_r, dnz_nxt;

  logic          u_start;
  logic [VW-1:0] u_a, u_b;
  logic [DW-1:0] u_dvsr;
  logic [P-1:0]  u_add;
  logic          u_done;
  logic [P:0]    u_res;

  cke_pkg::cke_mode_t mode;
  logic [3:0]    digit;
  logic [2:0]    opc;
  logic [VW-1:0] cur_v;
  logic          accept;

  logic          as_na, as_nb, as_neg;
  logic [VW-1:0] as_ma, as_mb;
  logic [P:0]    as_mag;
  logic [VW-1:0] as_val;
  logic          as_ovf;

  logic [VW-1:0] fin_r1, fin_r2, fin_val;
  logic          fin_o1, fin_o2, fin_neg2, fin_flip, fin_ovf;
  logic [P:0]    fin_m2;

  function automatic logic [VW-1:0] mag_of(input logic [VW-1:0] v);
    return v[VW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [VW:0] lim_of(input logic neg);
    return {2'b00, {(VW-1){1'b1}}} + (VW+1)'(neg);
  endfunction

  function automatic logic sat_ovf(input logic neg, input logic [P:0] m);
    return m > (P+1)'(lim_of(neg));
  endfunction

  function automatic logic [VW-1:0] sat_val(input logic neg, input logic [P:0] m);
    logic [VW:0]   lim;
    logic [VW-1:0] mm;
    lim = lim_of(neg);
    mm  = (m > (P+1)'(lim)) ? lim[VW-1:0] : m[VW-1:0];
    return neg ? (~mm + 1'b1) : mm;
  endfunction

  cke_muldiv #(.VW(VW)) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (u_start),
    .a_mag  (u_a),
    .b_mag  (u_b),
    .dvsr   (u_dvsr),
    .addend (u_add),
    .done   (u_done),
    .result (u_res)
  );

  assign mode   = cke_pkg::cke_mode_t'(in_tuser[2:0]);
  assign digit  = in_tdata[3:0];
  assign opc    = in_tdata[6:4];
  assign accept = in_tvalid && in_tready;
  assign cur_v  = (phase_r == cke_pkg::PH_SECOND) ? second_r :
                  (phase_r == cke_pkg::PH_RESULT) ? '0 : first_r;

  // signed add/subtract of the operands for equals
  always_comb begin
    as_na = first_r[VW-1];
    as_nb = (pop_r == cke_pkg::OP_SUB) ? ~second_r[VW-1] : second_r[VW-1];
    as_ma = mag_of(first_r);
    as_mb = mag_of(second_r);
    if (as_na == as_nb) begin
      as_mag = (P+1)'({1'b0, as_ma} + {1'b0, as_mb});
      as_neg = as_na;
    end else if (as_ma >= as_mb) begin
      as_mag = (P+1)'(as_ma - as_mb);
      as_neg = as_na;
    end else begin
      as_mag = (P+1)'(as_mb - as_ma);
      as_neg = as_nb;
    end
    as_val = sat_val(as_neg, as_mag);
    as_ovf = sat_ovf(as_neg, as_mag);
  end

  // saturate the unit result, then apply a pending minus on a digit
  always_comb begin
    fin_r1   = sat_val(jneg_r, u_res);
    fin_o1   = sat_ovf(jneg_r, u_res);
    fin_neg2 = ~fin_r1[VW-1];
    fin_m2   = (P+1)'(mag_of(fin_r1));
    fin_r2   = sat_val(fin_neg2, fin_m2);
    fin_o2   = sat_ovf(fin_neg2, fin_m2);
    fin_flip = dig_r && sign_r && dnz_r;
    fin_val  = fin_flip ? fin_r2 : fin_r1;
    fin_ovf  = fin_o1 | (fin_flip & fin_o2);
  end

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    shown_nxt     = shown_r;
    phase_nxt     = phase_r;
    pop_nxt       = pop_r;
    frac_nxt      = frac_r;
    place_nxt     = place_r;
    sign_nxt      = sign_r;
    err_nxt       = err_r;
    ovf_nxt       = ovf_r;
    to_second_nxt = to_second_r;
    jneg_nxt      = jneg_r;
    dig_nxt       = dig_r;
    dnz_nxt       = dnz_r;
    u_start       = 1'b0;
    u_a           = mag_of(cur_v);
    u_b           = VW'(1);
    u_dvsr        = DW'(1);
    u_add         = '0;
    in_tready     = (state_r == cke_pkg::ST_IDLE);
    case (state_r)
      cke_pkg::ST_IDLE: begin
        if (accept) begin
          ovf_nxt   = 1'b0;
          state_nxt = cke_pkg::ST_OUT;
          case (mode)
            cke_pkg::MODE_DIGIT: begin
              if (digit <= cke_pkg::DIGIT_MAX) begin
                err_nxt = 1'b0;
                if (phase_r != cke_pkg::PH_SECOND) begin
                  phase_nxt = cke_pkg::PH_FIRST;
                  if (phase_r == cke_pkg::PH_RESULT) first_nxt = '0;
                end
                if (frac_r && (place_r > 4'(FRAC_DIGITS) || place_r == 4'd0)) begin
                  // beyond precision: value holds, sign stays pending
                  shown_nxt = cur_v;
                end else begin
                  u_start       = 1'b1;
                  jneg_nxt      = cur_v[VW-1];
                  to_second_nxt = (phase_r == cke_pkg::PH_SECOND);
                  dig_nxt       = 1'b1;
                  dnz_nxt       = (digit != 4'd0);
                  if (frac_r) begin
                    u_add     = P'(digit) * P'(cke_pkg::pow10(4'(FRAC_DIGITS) - place_r));
                    place_nxt = place_r + 4'd1;
                  end else begin
                    u_b   = VW'(10);
                    u_add = P'(digit) * P'(cke_pkg::pow10(4'(FRAC_DIGITS)));
                  end
                  state_nxt = cke_pkg::ST_WAIT;
                end
              end
            end
            cke_pkg::MODE_OP: begin
              if (!err_r && opc >= cke_pkg::OP_ADD && opc <= cke_pkg::OP_DIV) begin
                if (opc == cke_pkg::OP_SUB && !sign_r &&
                    ((phase_r == cke_pkg::PH_FIRST && first_r == '0) ||
                     (phase_r == cke_pkg::PH_SECOND && second_r == '0))) begin
                  sign_nxt = 1'b1;
                end else begin
                  phase_nxt = cke_pkg::PH_SECOND;
                  pop_nxt   = opc;
                  frac_nxt  = 1'b0;
                  place_nxt = 4'd1;
                  sign_nxt  = 1'b0;
                end
              end
            end
            cke_pkg::MODE_EQ: begin
              if (phase_r == cke_pkg::PH_SECOND) begin
                second_nxt = '0;
                phase_nxt  = cke_pkg::PH_RESULT;
                sign_nxt   = 1'b0;
                to_second_nxt = 1'b0;
                dig_nxt    = 1'b0;
                jneg_nxt   = first_r[VW-1] ^ second_r[VW-1];
                if (pop_r == cke_pkg::OP_ADD || pop_r == cke_pkg::OP_SUB) begin
                  first_nxt = as_val;
                  shown_nxt = as_val;
                  ovf_nxt   = as_ovf;
                end else if (pop_r == cke_pkg::OP_MUL) begin
                  u_start   = 1'b1;
                  u_a       = mag_of(first_r);
                  u_b       = mag_of(second_r);
                  u_dvsr    = DW'(cke_pkg::pow10(4'(FRAC_DIGITS)));
                  state_nxt = cke_pkg::ST_WAIT;
                end else if (second_r != '0) begin
                  u_start   = 1'b1;
                  u_a       = mag_of(first_r);
                  u_b       = VW'(cke_pkg::pow10(4'(FRAC_DIGITS)));
                  u_dvsr    = DW'(mag_of(second_r));
                  state_nxt = cke_pkg::ST_WAIT;
                end else begin
                  err_nxt   = 1'b1;
                  shown_nxt = first_r;
                end
              end
            end
            cke_pkg::MODE_DOT: frac_nxt = 1'b1;
            cke_pkg::MODE_CLR: begin
              first_nxt  = '0;
              second_nxt = '0;
              shown_nxt  = '0;
              phase_nxt  = cke_pkg::PH_FIRST;
              pop_nxt    = cke_pkg::OP_NONE;
              frac_nxt   = 1'b0;
              place_nxt  = 4'd1;
              sign_nxt   = 1'b0;
              err_nxt    = 1'b0;
            end
            cke_pkg::MODE_CE: begin
              if (phase_r != cke_pkg::PH_SECOND) first_nxt = '0;
              else second_nxt = '0;
              shown_nxt = '0;
              frac_nxt  = 1'b0;
              place_nxt = 4'd1;
              sign_nxt  = 1'b0;
              err_nxt   = 1'b0;
            end
            cke_pkg::MODE_PCT: begin
              u_start = 1'b1;
              dig_nxt = 1'b0;
              u_a     = mag_of(first_r);
              if (phase_r == cke_pkg::PH_SECOND) begin
                u_b           = mag_of(second_r);
                u_dvsr        = DW'(cke_pkg::pow10(4'(FRAC_DIGITS + 2)));
                jneg_nxt      = first_r[VW-1] ^ second_r[VW-1];
                to_second_nxt = 1'b1;
              end else begin
                u_dvsr        = DW'(100);
                jneg_nxt      = first_r[VW-1];
                to_second_nxt = 1'b0;
              end
              state_nxt = cke_pkg::ST_WAIT;
            end
            default: ;
          endcase
        end
      end
      cke_pkg::ST_WAIT: begin
        if (u_done) begin
          if (to_second_r) second_nxt = fin_val;
          else first_nxt = fin_val;
          shown_nxt = fin_val;
          ovf_nxt   = fin_ovf;
          if (fin_flip) sign_nxt = 1'b0;
          state_nxt = cke_pkg::ST_OUT;
        end
      end
      cke_pkg::ST_OUT: begin
        if (out_tready) state_nxt = cke_pkg::ST_IDLE;
      end
      default: state_nxt = cke_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cke_pkg::ST_IDLE;
      first_r  <= '0;
      second_r <= '0;
      shown_r  <= '0;
      phase_r  <= cke_pkg::PH_FIRST;
      pop_r    <= cke_pkg::OP_NONE;
      frac_r   <= 1'b0;
      place_r  <= 4'd1;
      sign_r   <= 1'b0;
      err_r    <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      shown_r  <= shown_nxt;
      phase_r  <= phase_nxt;
      pop_r    <= pop_nxt;
      frac_r   <= frac_nxt;
      place_r  <= place_nxt;
      sign_r   <= sign_nxt;
      err_r    <= err_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    to_second_r <= to_second_nxt;
    jneg_r      <= jneg_nxt;
    dig_r       <= dig_nxt;
    dnz_r       <= dnz_nxt;
  end

  assign out_tvalid = (state_r == cke_pkg::ST_OUT);
  assign out_tdata  = {2'b00, ovf_r, frac_r, sign_r, err_r, phase_r,
                       cke_pkg::OUT_W'($signed(shown_r))};

endmodule
`default_nettype wire

// ===== src/cke_muldiv.sv =====
`default_nettype none
module cke_muldiv #(
  parameter int VW = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [VW-1:0]               a_mag,
  input  wire logic [VW-1:0]               b_mag,
  input  wire logic [cke_pkg::DIV_W-1:0]   dvsr,
  input  wire logic [2*VW-1:0]             addend,
  output logic                             done,
  output logic [2*VW:0]                    result
);

  localparam int P  = 2 * VW;
  localparam int DW = cke_pkg::DIV_W;
  localparam int CW = $clog2(P + 1);

  cke_pkg::cke_ustate_t state_r, state_nxt;
  logic [P-1:0]  acc_r, acc_nxt;
  logic [P-1:0]  mcand_r, mcand_nxt;
  logic [VW-1:0] mplier_r, mplier_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] dvsr_r, dvsr_nxt;
  logic [P-1:0]  addend_r, addend_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [P:0]    res_r, res_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_r[DW-1:0], acc_r[P-1]};
  assign ge     = rem_sh >= {1'b0, dvsr_r};

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    rem_nxt    = rem_r;
    dvsr_nxt   = dvsr_r;
    addend_nxt = addend_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    done_nxt   = 1'b0;
    case (state_r)
      cke_pkg::US_IDLE: begin
        if (start) begin
          acc_nxt    = '0;
          mcand_nxt  = P'(a_mag);
          mplier_nxt = b_mag;
          dvsr_nxt   = dvsr;
          addend_nxt = addend;
          cnt_nxt    = CW'(VW);
          state_nxt  = cke_pkg::US_MUL;
        end
      end
      cke_pkg::US_MUL: begin
        // shift-add, one multiplier bit per cycle
        if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          cnt_nxt   = CW'(P);
          rem_nxt   = '0;
          state_nxt = cke_pkg::US_DIV;
        end
      end
      cke_pkg::US_DIV: begin
        // restoring divide, quotient bits shift into acc
        rem_nxt = ge ? (rem_sh - {1'b0, dvsr_r}) : rem_sh;
        acc_nxt = {acc_r[P-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = cke_pkg::US_ADD;
      end
      cke_pkg::US_ADD: begin
        res_nxt   = {1'b0, acc_r} + {1'b0, addend_r};
        done_nxt  = 1'b1;
        state_nxt = cke_pkg::US_IDLE;
      end
      default: state_nxt = cke_pkg::US_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cke_pkg::US_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    rem_r    <= rem_nxt;
    dvsr_r   <= dvsr_nxt;
    addend_r <= addend_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
`default_nettype wire

// ===== src/cke_checker.sv =====
`default_nettype none
`include "calculator_key_engine_macros.svh"
module cke_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [cke_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  `CKE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CKE_ASSERT_SAME(a_one_in_flight, out_tvalid, !in_tready)
  `CKE_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `CKE_ASSERT_NEXT(a_ready_after_result, out_tvalid && out_tready, in_tready && !out_tvalid)
  `CKE_ASSERT_SAME(a_error_in_result, out_tvalid && out_tdata[66], out_tdata[65:64] == cke_pkg::PH_RESULT)

endmodule

bind calculator_key_engine cke_checker u_cke_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== bench/calculator_key_engine_tb.sv =====
module calculator_key_engine_tb;

  localparam logic [2:0] MODE_SPARE = 3'd7;
  localparam logic [63:0] SCALE = 64'd1000000;
  localparam int FRAC = 6;
  localparam int LIMIT = 3000000;
  localparam int PHASE_KEYS = 189;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [cke_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [cke_pkg::IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [cke_pkg::OUT_TDATA_W-1:0] out_tdata;

  calculator_key_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // packed from the top bit down, matching out_tdata[69:0]
  typedef struct packed {
    logic        ovf;
    logic        dec;
    logic        minus;
    logic        err;
    logic [1:0]  phase;
    logic [63:0] value;
  } status_t;

  typedef struct {
    logic [2:0]  mode;
    logic [3:0]  digit;
    logic [2:0]  op;
    bit          typed;
    logic [63:0] value;
  } key_row_t;

  // calculator state mirror
  logic signed [63:0] acc_first, acc_second, shown;
  logic [1:0] key_phase;
  logic [2:0] op_pending;
  int frac_pos;
  bit frac_on, neg_armed, err_on, ovf_hit;

  status_t display_q[$];
  logic [63:0] typed_q[$];
  bit typed_flag_q[$];
  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] clamp_value(bit neg, logic [127:0] m);
    logic [127:0] lim;
    lim = {65'd0, 63'h7fff_ffff_ffff_ffff} + (neg ? 128'd1 : 128'd0);
    if (m > lim) begin
      ovf_hit = 1;
      m = lim;
    end
    return neg ? (~m[63:0] + 64'd1) : m[63:0];
  endfunction

  function automatic logic [63:0] sum_signed(bit na, logic [63:0] ma, bit nb,
                                             logic [63:0] mb);
    if (na == nb) return clamp_value(na, {64'd0, ma} + {64'd0, mb});
    if (ma >= mb) return clamp_value(na, {64'd0, ma - mb});
    return clamp_value(nb, {64'd0, mb - ma});
  endfunction

  function automatic logic [63:0] product_div(logic signed [63:0] a,
                                              logic signed [63:0] b,
                                              logic [127:0] divisor);
    logic [127:0] p;
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    return clamp_value(a[63] != b[63], p / divisor);
  endfunction

  function automatic logic [63:0] push_digit(logic signed [63:0] v, int d);
    logic [127:0] m;
    logic signed [63:0] r;
    if (frac_on) begin
      if (frac_pos > FRAC || frac_pos == 0) return v;
      m = {64'd0, mag(v)} + 128'(d) * 128'(10 ** (FRAC - frac_pos));
      frac_pos++;
    end else begin
      m = {64'd0, mag(v)} * 128'd10 + 128'(d) * {64'd0, SCALE};
    end
    r = clamp_value(v[63], m);
    if (neg_armed && d != 0) begin
      r = clamp_value(!r[63], {64'd0, mag(r)});
      neg_armed = 0;
    end
    return r;
  endfunction

  function automatic void clear_all();
    acc_first = 0; acc_second = 0; shown = 0;
    key_phase = cke_pkg::PH_FIRST; op_pending = cke_pkg::OP_NONE;
    frac_on = 0; frac_pos = 1; neg_armed = 0; err_on = 0;
  endfunction

  function automatic status_t press_key(logic [2:0] mode, logic [3:0] d,
                                        logic [2:0] op);
    status_t s;
    ovf_hit = 0;
    case (mode)
      cke_pkg::MODE_DIGIT: if (d <= cke_pkg::DIGIT_MAX) begin
        err_on = 0;
        if (key_phase == cke_pkg::PH_SECOND) begin
          acc_second = push_digit(acc_second, d);
          shown = acc_second;
        end else begin
          if (key_phase == cke_pkg::PH_RESULT) acc_first = 0;
          acc_first = push_digit(acc_first, d);
          shown = acc_first;
          key_phase = cke_pkg::PH_FIRST;
        end
      end
      cke_pkg::MODE_OP: if (!err_on && op >= cke_pkg::OP_ADD && op <= cke_pkg::OP_DIV) begin
        if (op == cke_pkg::OP_SUB && !neg_armed &&
            ((key_phase == cke_pkg::PH_FIRST && acc_first == 0) ||
             (key_phase == cke_pkg::PH_SECOND && acc_second == 0))) begin
          neg_armed = 1;
        end else begin
          key_phase = cke_pkg::PH_SECOND;
          op_pending = op;
          frac_on = 0; frac_pos = 1; neg_armed = 0;
        end
      end
      cke_pkg::MODE_EQ: if (key_phase == cke_pkg::PH_SECOND) begin
        if (op_pending == cke_pkg::OP_ADD)
          acc_first = sum_signed(acc_first[63], mag(acc_first),
                                 acc_second[63], mag(acc_second));
        else if (op_pending == cke_pkg::OP_SUB)
          acc_first = sum_signed(acc_first[63], mag(acc_first),
                                 !acc_second[63], mag(acc_second));
        else if (op_pending == cke_pkg::OP_MUL)
          acc_first = product_div(acc_first, acc_second, {64'd0, SCALE});
        else if (acc_second != 0)
          acc_first = clamp_value(acc_first[63] != acc_second[63],
                                  ({64'd0, mag(acc_first)} * {64'd0, SCALE})
                                  / {64'd0, mag(acc_second)});
        else
          err_on = 1;
        shown = acc_first;
        acc_second = 0;
        key_phase = cke_pkg::PH_RESULT;
        neg_armed = 0;
      end
      cke_pkg::MODE_DOT: frac_on = 1;
      cke_pkg::MODE_CLR: clear_all();
      cke_pkg::MODE_CE: begin
        if (key_phase != cke_pkg::PH_SECOND) acc_first = 0;
        else acc_second = 0;
        shown = 0; frac_on = 0; frac_pos = 1; neg_armed = 0; err_on = 0;
      end
      cke_pkg::MODE_PCT: begin
        if (key_phase == cke_pkg::PH_SECOND) begin
          acc_second = product_div(acc_first, acc_second, {64'd0, SCALE} * 100);
          shown = acc_second;
        end else begin
          acc_first = clamp_value(acc_first[63], {64'd0, mag(acc_first) / 64'd100});
          shown = acc_first;
        end
      end
      default: ;
    endcase
    s.value = shown; s.phase = key_phase; s.err = err_on;
    s.minus = neg_armed; s.dec = frac_on; s.ovf = ovf_hit;
    return s;
  endfunction

  // scoreboard: predict on acceptance, compare on result
  bit pending_typed = 0;
  logic [63:0] pending_value;

  always @(posedge clk) begin
    status_t got, want;
    logic [63:0] tv;
    bit tf;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        display_q.push_back(press_key(in_tuser, in_tdata[3:0], in_tdata[6:4]));
        typed_q.push_back(pending_value);
        typed_flag_q.push_back(pending_typed);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[69:0];
        if (display_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item %h", got);
        end else begin
          want = display_q.pop_front();
          tv = typed_q.pop_front();
          tf = typed_flag_q.pop_front();
          if (got !== want || (tf && got.value !== tv)) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: value exp %0d got %0d, phase %0d/%0d err %0b/%0b",
                       $signed(want.value), $signed(got.value), want.phase,
                       got.phase, want.err, got.err,
                       " minus %0b/%0b dec %0b/%0b ovf %0b/%0b",
                       want.minus, got.minus, want.dec, got.dec, want.ovf, got.ovf);
          end
        end
      end
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_key(logic [2:0] mode, logic [3:0] d, logic [2:0] op,
                          bit typed, logic [63:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= {1'b0, op, d};
    pending_typed <= typed;
    pending_value <= value;
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  task automatic random_key();
    int r;
    r = $urandom_range(99);
    if (r < 45)
      send_key(cke_pkg::MODE_DIGIT, 4'($urandom_range(9)), 3'($urandom_range(7)), 0, 0);
    else if (r < 49)
      send_key(cke_pkg::MODE_DIGIT, 4'($urandom_range(15, 10)), 3'($urandom_range(7)),
               0, 0);
    else if (r < 62)
      send_key(cke_pkg::MODE_OP, 4'($urandom_range(15)), 3'($urandom_range(4, 1)), 0, 0);
    else if (r < 65)
      send_key(cke_pkg::MODE_OP, 4'($urandom_range(15)),
               $urandom_range(1) ? cke_pkg::OP_NONE : 3'($urandom_range(7, 5)), 0, 0);
    else if (r < 76)
      send_key(cke_pkg::MODE_EQ, 4'($urandom_range(15)), 3'($urandom_range(7)), 0, 0);
    else if (r < 83)
      send_key(cke_pkg::MODE_DOT, 4'($urandom_range(15)), 3'($urandom_range(7)), 0, 0);
    else if (r < 86)
      send_key(cke_pkg::MODE_CLR, 4'($urandom_range(15)), 3'($urandom_range(7)), 0, 0);
    else if (r < 89)
      send_key(cke_pkg::MODE_CE, 4'($urandom_range(15)), 3'($urandom_range(7)), 0, 0);
    else if (r < 95)
      send_key(cke_pkg::MODE_PCT, 4'($urandom_range(15)), 3'($urandom_range(7)), 0, 0);
    else if (r < 97)
      send_key(MODE_SPARE, 4'($urandom_range(15)), 3'($urandom_range(7)), 0, 0);
    else begin
      // long digit run to drive entry into saturation
      repeat ($urandom_range(20, 12))
        send_key(cke_pkg::MODE_DIGIT, 4'($urandom_range(9, 1)), 3'($urandom_range(7)),
                 0, 0);
    end
  endtask

  key_row_t keys[] = '{
    '{MODE_SPARE,          4'd0,  cke_pkg::OP_NONE, 1, 64'd0},
    '{cke_pkg::MODE_DIGIT, 4'd9,  cke_pkg::OP_NONE, 1, 64'd9000000},
    '{cke_pkg::MODE_DIGIT, 4'd15, cke_pkg::OP_NONE, 1, 64'd9000000},
    '{cke_pkg::MODE_DOT,   4'd0,  cke_pkg::OP_NONE, 0, 64'd0},
    '{cke_pkg::MODE_DIGIT, 4'd5,  cke_pkg::OP_NONE, 1, 64'd9500000},
    '{cke_pkg::MODE_OP,    4'd0,  cke_pkg::OP_SUB,  0, 64'd0},
    '{cke_pkg::MODE_OP,    4'd0,  cke_pkg::OP_SUB,  0, 64'd0},
    '{cke_pkg::MODE_OP,    4'd0,  cke_pkg::OP_ADD,  0, 64'd0},
    '{cke_pkg::MODE_OP,    4'd0,  cke_pkg::OP_NONE, 0, 64'd0},
    '{cke_pkg::MODE_OP,    4'd0,  3'd7,             0, 64'd0},
    '{cke_pkg::MODE_DIGIT, 4'd0,  cke_pkg::OP_NONE, 0, 64'd0},
    '{cke_pkg::MODE_DIGIT, 4'd3,  cke_pkg::OP_NONE, 1, 64'd3000000},
    '{cke_pkg::MODE_PCT,   4'd0,  cke_pkg::OP_NONE, 1, 64'd285000},
    '{cke_pkg::MODE_EQ,    4'd0,  cke_pkg::OP_NONE, 1, 64'd9785000},
    '{cke_pkg::MODE_EQ,    4'd0,  cke_pkg::OP_NONE, 1, 64'd9785000},
    '{cke_pkg::MODE_OP,    4'd0,  cke_pkg::OP_DIV,  0, 64'd0},
    '{cke_pkg::MODE_EQ,    4'd0,  cke_pkg::OP_NONE, 1, 64'd9785000},
    '{cke_pkg::MODE_OP,    4'd0,  cke_pkg::OP_MUL,  0, 64'd0},
    '{cke_pkg::MODE_CE,    4'd0,  cke_pkg::OP_NONE, 1, 64'd0},
    '{cke_pkg::MODE_DOT,   4'd0,  cke_pkg::OP_NONE, 0, 64'd0},
    '{cke_pkg::MODE_DIGIT, 4'd1,  cke_pkg::OP_NONE, 0, 64'd0},
    '{cke_pkg::MODE_PCT,   4'd0,  cke_pkg::OP_NONE, 0, 64'd0},
    '{cke_pkg::MODE_CLR,   4'd0,  cke_pkg::OP_NONE, 1, 64'd0},
    '{cke_pkg::MODE_OP,    4'd0,  cke_pkg::OP_SUB,  1, 64'd0},
    '{cke_pkg::MODE_DIGIT, 4'd7,  cke_pkg::OP_NONE, 1, -64'sd7000000}
  };

  initial begin
    clear_all();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (keys[i]) send_key(keys[i].mode, keys[i].digit, keys[i].op,
                               keys[i].typed, keys[i].value);
    // digit run long enough to saturate, then a fraction past precision
    repeat (21) send_key(cke_pkg::MODE_DIGIT, 4'd9, cke_pkg::OP_NONE, 0, 0);
    send_key(cke_pkg::MODE_CLR, 4'd0, cke_pkg::OP_NONE, 0, 0);
    send_key(cke_pkg::MODE_DOT, 4'd0, cke_pkg::OP_NONE, 0, 0);
    repeat (8) send_key(cke_pkg::MODE_DIGIT, 4'd8, cke_pkg::OP_NONE, 0, 0);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 33 : 69) : 0;
      stall_pct = (ph == 2) ? 69 : ((ph == 3) ? 33 : 0);
      repeat (PHASE_KEYS) random_key();
    end
    in_tvalid <= 0;
    @(posedge clk);
    wait (display_q.size() == 0);
    repeat (400) @(posedge clk);
    // a result that never came counts as a mismatch
    if (display_q.size() != 0) mismatches++;
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
